/* rtl/wavetable_oscillator_interp_top_assert.svh */
// assertion macros for the wavetable oscillator
// no dependencies; included by the top level, which supplies i_clk and i_rst_n
`ifndef WAVETABLE_OSCILLATOR_INTERP_TOP_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_INTERP_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define WTO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define WTO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define WTO_ASSERT(lbl, prop, msg)
`define WTO_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/wto_pkg.sv */
// shared types and constants for the wavetable oscillator
// used by wto_ctrl, wto_dp and wavetable_oscillator_interp_top
package wto_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int SAMPLE_W    = 16;
    localparam int PHASE_W     = 16;
    localparam int GAIN_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [GAIN_W-1:0]  RST_GAIN      = 8'd255;
    localparam logic [PHASE_W-1:0] RST_PHASE_INC = 16'd900;

    // item operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BIAS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_INPUT_STEP  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDH,
        S_INTERP,
        S_SCALE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic wr_table;   // store one table word
        logic start_tick; // read low entry, latch the phase step
        logic rd_hi;      // read high entry, hold low entry
        logic interp;     // interpolate
        logic scale;      // apply gain
        logic load_out;   // bias, saturate, advance phase
    } t_dp_cmd;

endpackage

/* rtl/wto_ctrl.sv */
// controller state machine for the wavetable oscillator
// depends on wto_pkg; drives the datapath command struct and both handshakes
module wto_ctrl import wto_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_operation,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_operation == OP_WRITE) begin
                        o_cmd.wr_table = 1'b1;
                    end else begin
                        o_cmd.start_tick = 1'b1;
                        n_state          = S_RDH;
                    end
                end
            end
            S_RDH: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state      = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                // wait until the output register is free
                if (!(r_out_valid && i_out_stall)) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out | (r_out_valid & i_out_stall);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/wto_dp.sv */
// datapath of the wavetable oscillator: table memory, phase, interpolation
// depends on wto_pkg; sequenced by wto_ctrl through t_dp_cmd
module wto_dp import wto_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [TBL_AW-1:0]           i_table_address,
    input  logic signed [SAMPLE_W-1:0]  i_table_value,
    input  logic [PHASE_W-1:0]          i_step_in,
    output logic signed [SAMPLE_W-1:0]  o_sample
);

    localparam logic signed [20:0] SAT_HI = 21'sd32767;
    localparam logic signed [20:0] SAT_LO = -21'sd32768;

    logic signed [SAMPLE_W-1:0] r_bias;
    logic [GAIN_W-1:0]          r_gain;
    logic [PHASE_W-1:0]         r_phase_inc;
    logic                       r_use_step;
    logic [PHASE_W-1:0]         r_phase;
    logic [PHASE_W-1:0]         r_step;

    logic signed [SAMPLE_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic signed [SAMPLE_W-1:0] r_s_l;
    logic signed [18:0]         r_interp_sum;
    logic signed [19:0]         r_scaled;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic [TBL_AW-1:0]   rd_addr;
    logic signed [16:0]  diff;
    logic signed [25:0]  frac_prod;
    logic signed [18:0]  interp_sum;
    logic signed [27:0]  gain_prod;
    logic signed [20:0]  total;
    logic signed [SAMPLE_W-1:0] sat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias      <= '0;
            r_gain      <= RST_GAIN;
            r_phase_inc <= RST_PHASE_INC;
            r_use_step  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OUTPUT_BIAS:     r_bias      <= $signed(i_cfg_data[SAMPLE_W-1:0]);
                CFG_OUTPUT_GAIN:     r_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_PHASE_INCREMENT: r_phase_inc <= i_cfg_data[PHASE_W-1:0];
                CFG_USE_INPUT_STEP:  r_use_step  <= i_cfg_data[0];
            endcase
        end
    end

    // phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.load_out) begin
            r_phase <= r_phase + r_step;
        end
    end

    // low entry at the top phase byte, high entry at the next index
    assign rd_addr = i_cmd.rd_hi ? TBL_AW'(r_phase[PHASE_W-1 -: TBL_AW] + 1'b1)
                                 : r_phase[PHASE_W-1 -: TBL_AW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_table) begin
            r_mem[i_table_address] <= i_table_value;
        end
        if (i_cmd.start_tick || i_cmd.rd_hi) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign diff       = {r_rd_data[SAMPLE_W-1], r_rd_data} - {r_s_l[SAMPLE_W-1], r_s_l};
    assign frac_prod  = diff * $signed({1'b0, r_phase[7:0]});
    assign interp_sum = {{3{r_s_l[SAMPLE_W-1]}}, r_s_l} + {frac_prod[25], frac_prod[25:8]};
    assign gain_prod  = r_interp_sum * $signed({1'b0, r_gain});
    assign total      = {r_scaled[19], r_scaled} + {{5{r_bias[SAMPLE_W-1]}}, r_bias};

    always_comb begin
        if (total > SAT_HI) begin
            sat = SAT_HI[SAMPLE_W-1:0];
        end else if (total < SAT_LO) begin
            sat = SAT_LO[SAMPLE_W-1:0];
        end else begin
            sat = total[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_tick) begin
            r_step <= r_use_step ? i_step_in : r_phase_inc;
        end
        if (i_cmd.rd_hi) begin
            r_s_l <= r_rd_data;
        end
        if (i_cmd.interp) begin
            r_interp_sum <= interp_sum;
        end
        if (i_cmd.scale) begin
            r_scaled <= gain_prod[27:8];
        end
        if (i_cmd.load_out) begin
            r_sample <= sat;
        end
    end

    assign o_sample = r_sample;

endmodule

/* rtl/wavetable_oscillator_interp_top.sv */
// wavetable oscillator with linear interpolation, top level; uses wto_pkg, wto_ctrl, wto_dp
// a tick transaction steps through S_RDH, S_INTERP, S_SCALE and S_OUT, which loads the sample
// once the output register is free; no new transaction is taken until S_IDLE again, the
// sequence being set by the single-port table read and the two registered multiplies; table
// writes give no sample; synchronous active-low reset clears phase, control and config
// registers (gain 255, step 900); the table is not cleared and must be written before it is read
`include "wavetable_oscillator_interp_top_assert.svh"

module wavetable_oscillator_interp_top import wto_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [TBL_AW-1:0]           i_table_address,
    input  logic signed [SAMPLE_W-1:0]  i_table_value,
    input  logic [PHASE_W-1:0]          i_step_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [SAMPLE_W-1:0]  o_sample,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    t_dp_cmd cmd;
    logic    tick_accept;

    wto_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    wto_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_table_address (i_table_address),
        .i_table_value   (i_table_value),
        .i_step_in       (i_step_in),
        .o_sample        (o_sample)
    );

    assign tick_accept = i_in_valid && !o_in_stall && (i_operation == OP_TICK);

    `WTO_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset did not clear handshakes")
    `WTO_ASSERT(a_tick_busy, tick_accept |=> o_in_stall, "tick transaction did not make block busy")
    `WTO_ASSERT(a_tick_result, tick_accept |-> ##5 o_out_valid, "no sample after tick")

endmodule
